// ----- hw/rtl/firq_pkg.sv -----
// Shared types and constants for the Q16 FIR filter.
package firq_pkg;

  localparam int MAX_TAPS  = 64;
  localparam int IDX_W     = $clog2(MAX_TAPS);
  localparam int CNT_W     = 7;
  localparam int DATA_W    = 16;
  localparam int ACC_W     = 32;
  localparam int OUT_SHIFT = 16;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);
  // Restoring reduction of the write position modulo the tap count.
  localparam int RED_STEPS = IDX_W;
  localparam int RED_W     = IDX_W + RED_STEPS;
  localparam int STEP_W    = $clog2(RED_STEPS);

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_FILTER = 1'b1;

  typedef struct packed {
    logic                     op;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

endpackage

// ----- hw/rtl/firq_front.sv -----
// Input side: takes stream items, classifies them and queues commands for the engine.
module firq_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [39:0]        in_tdata,
  input  logic               in_tuser,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output firq_pkg::cmd_t     cmd
);

  firq_pkg::cmd_t                    q_r [firq_pkg::QDEPTH];
  logic [firq_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [firq_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [firq_pkg::QCNT_W-1:0]       count_r, count_nxt;
  firq_pkg::cmd_t                    in_cmd;
  logic                              push, pop;

  // A filter item carries the sample in the value slot, a load item the coefficient.
  always_comb begin
    in_cmd.op    = in_tuser;
    in_cmd.idx   = in_tdata[firq_pkg::IDX_W-1:0];
    in_cmd.value = (in_tuser == firq_pkg::OP_FILTER) ? in_tdata[37:22] : in_tdata[21:6];
  end

  assign in_tready = (count_r != firq_pkg::QCNT_W'(firq_pkg::QDEPTH));
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (count_r != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

// ----- hw/rtl/firq_back.sv -----
// Engine: coefficient and history memories, multiply-accumulate sequencer and output register.
module firq_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  firq_pkg::cmd_t              cmd,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [firq_pkg::CNT_W-1:0]  cfg_data,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_REDUCE = 5'b00010,
    ST_MAC    = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  localparam int IW = firq_pkg::IDX_W;
  localparam int CW = firq_pkg::CNT_W;
  localparam int DW = firq_pkg::DATA_W;
  localparam int AW = firq_pkg::ACC_W;
  localparam int RW = firq_pkg::RED_W;

  state_t                     state_r, state_nxt;
  logic [CW-1:0]              tap_count_r, tap_count_nxt;
  logic [CW-1:0]              n_eff;
  logic [IW-1:0]              wp_r, wp_nxt;
  logic [IW-1:0]              k_r, k_nxt;
  logic [IW-1:0]              i_r, i_nxt;
  logic [firq_pkg::STEP_W-1:0] s_r, s_nxt;
  logic [AW-1:0]              acc_r, acc_nxt;
  logic                       v1_r, v2_r;
  logic                       out_valid_r, out_valid_nxt;
  logic [DW-1:0]              out_data_r;
  logic                       out_load;
  logic [firq_pkg::MAX_TAPS-1:0] hist_vld_r, hist_vld_nxt;

  logic signed [DW-1:0]       coeff_mem [firq_pkg::MAX_TAPS];
  logic signed [DW-1:0]       hist_mem  [firq_pkg::MAX_TAPS];
  logic signed [DW-1:0]       coeff_rd_r, hist_rd_r, hist_op;
  logic                       hist_ok_r;
  logic signed [AW-1:0]       prod_r;

  logic                       pop, hist_we, coeff_we, issue, last_tap;
  logic [RW-1:0]              red_div, k_ext;
  logic                       red_sub;
  logic [IW-1:0]              k_red, k_inc;

  function automatic logic [IW-1:0] step_back(input logic [IW-1:0] k,
                                              input logic [CW-1:0] n);
    logic [CW-1:0] nm1;
    nm1 = n - 1'b1;
    return (k == '0) ? nm1[IW-1:0] : k - 1'b1;
  endfunction

  // A tap count of zero behaves as one, anything above the table depth as the depth.
  always_comb begin
    if (tap_count_r == '0) begin
      n_eff = CW'(1);
    end else if (tap_count_r > CW'(firq_pkg::MAX_TAPS)) begin
      n_eff = CW'(firq_pkg::MAX_TAPS);
    end else begin
      n_eff = tap_count_r;
    end
  end

  assign cfg_ready = 1'b1;
  assign cmd_ready = (state_r == ST_IDLE);
  assign pop       = cmd_valid && cmd_ready;
  assign hist_we   = pop && (cmd.op == firq_pkg::OP_FILTER);
  assign coeff_we  = pop && (cmd.op == firq_pkg::OP_LOAD);
  assign issue     = (state_r == ST_MAC);
  assign last_tap  = ({1'b0, i_r} == n_eff - 1'b1);
  assign k_inc     = ({1'b0, k_r} + 1'b1 == n_eff) ? '0 : k_r + 1'b1;

  assign red_div = RW'(n_eff) << s_r;
  assign k_ext   = RW'(k_r);
  assign red_sub = (k_ext >= red_div);
  assign k_red   = red_sub ? k_r - red_div[IW-1:0] : k_r;

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  assign hist_op  = hist_ok_r ? hist_rd_r : '0;

  always_comb begin
    state_nxt     = state_r;
    tap_count_nxt = tap_count_r;
    wp_nxt        = wp_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    s_nxt         = s_r;
    acc_nxt       = acc_r;
    hist_vld_nxt  = hist_vld_r;
    out_valid_nxt = out_valid_r;

    if (cfg_valid && cfg_ready) begin
      tap_count_nxt = cfg_data;
    end
    if (hist_we) begin
      hist_vld_nxt[wp_r] = 1'b1;
    end
    if (v2_r) begin
      acc_nxt = acc_r + AW'(prod_r);
    end
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (hist_we) begin
          acc_nxt = '0;
          k_nxt   = wp_r;
          i_nxt   = '0;
          if ({1'b0, wp_r} < n_eff) begin
            wp_nxt    = step_back(wp_r, n_eff);
            state_nxt = ST_MAC;
          end else begin
            // Position left beyond a shrunken tap count: reduce it first.
            s_nxt     = firq_pkg::STEP_W'(firq_pkg::RED_STEPS - 1);
            state_nxt = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        k_nxt = k_red;
        s_nxt = s_r - 1'b1;
        if (s_r == '0) begin
          wp_nxt    = step_back(k_red, n_eff);
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        i_nxt = i_r + 1'b1;
        k_nxt = k_inc;
        if (last_tap) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_r && !v2_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tap_count_r <= CW'(firq_pkg::MAX_TAPS);
      wp_r        <= '0;
      hist_vld_r  <= '0;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tap_count_r <= tap_count_nxt;
      wp_r        <= wp_nxt;
      hist_vld_r  <= hist_vld_nxt;
      out_valid_r <= out_valid_nxt;
      v1_r        <= issue;
      v2_r        <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    i_r   <= i_nxt;
    s_r   <= s_nxt;
    acc_r <= acc_nxt;
    if (v1_r) begin
      prod_r <= coeff_rd_r * hist_op;
    end
    if (out_load) begin
      out_data_r <= acc_r[firq_pkg::OUT_SHIFT +: DW];
    end
  end

  always_ff @(posedge clk) begin
    if (coeff_we) begin
      coeff_mem[cmd.idx] <= cmd.value;
    end
    if (issue) begin
      coeff_rd_r <= coeff_mem[i_r];
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[wp_r] <= cmd.value;
    end
    if (issue) begin
      hist_rd_r <= hist_mem[k_r];
      hist_ok_r <= hist_vld_r[k_r];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- hw/rtl/fir_filter_q16.sv -----
// Top level of the direct-form FIR filter on signed 16-bit samples.
// Input stream: in_tuser selects the item kind; zero loads one coefficient,
// one filters one sample. in_tdata carries the coefficient index, the
// coefficient and the sample. Every sample transaction gives one result on
// the output stream; a load transaction gives none.
// cfg_data sets the number of taps in use (zero acts as one, above 64 as 64);
// it must be written by the user only while the filter is idle; the block
// does not enforce this, and it is always accepted. A load is taken in the
// idle state and leaves the engine idle. A sample passes through idle,
// the MAC state, where the single shared multiply-accumulate unit walks
// one tap per cycle over the n taps in use, then drain and done; after the
// tap count shrinks below the current history position, a reduce state
// first brings it into range. The engine takes no command until idle again.
// A two-entry command queue lets new items enter while the engine works.
// A result waits in the output register while out_tready is low; the engine
// finishes the next sample and then holds until that register frees.
// Reset (rst_n low, synchronous) clears the history, the position and the
// queue and sets the tap count to 64; coefficients must be loaded before use.
module fir_filter_q16 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // coeff_index[5:0], coeff_value[21:6], sample[37:22], zero
  input  logic        in_tuser,   // opcode[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // filtered[15:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  firq_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_ready;

  firq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  firq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- hw/rtl/firq_checker.sv -----
// Port-level checker for the FIR filter and its bind to the top level.
module firq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // Sample transactions accepted whose result has not yet been taken.
  logic [3:0] pending_r, pending_nxt;
  logic       in_smp, out_xfer;

  assign in_smp   = in_tvalid && in_tready && (in_tuser == firq_pkg::OP_FILTER);
  assign out_xfer = out_tvalid && out_tready;

  always_comb begin
    pending_nxt = pending_r;
    if (in_smp && !out_xfer) begin
      pending_nxt = pending_r + 1'b1;
    end else if (out_xfer && !in_smp) begin
      pending_nxt = pending_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pending_r != '0)
    else $error("result without an accepted sample transaction");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 4'd4)
    else $error("more samples in flight than the queue and engine can hold");

endmodule

bind fir_filter_q16 firq_checker u_firq_checker (.*);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking stream testbench for the Q16 FIR filter with a tap-accurate predictor.
module testbench;

  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int SETTLE_CYCLES   = 2 * (firq_pkg::MAX_TAPS + 11);
  localparam int ITEMS_PER_PHASE = 100;
  localparam int NUM_PHASES      = 16;
  localparam int REPORT_LIMIT    = 10;

  // Tracks the filter state and holds the filtered values still owed by the block.
  class fir_q16_tracker;
    logic signed [firq_pkg::DATA_W-1:0] history [firq_pkg::MAX_TAPS];
    logic signed [firq_pkg::DATA_W-1:0] coeffs [firq_pkg::MAX_TAPS];
    logic [firq_pkg::IDX_W-1:0]         wr_pos;
    logic [firq_pkg::CNT_W-1:0]         tap_reg;
    logic [firq_pkg::DATA_W-1:0]        filtered_q [$];
    int                                 mismatches;

    function new();
      foreach (history[i]) begin
        history[i] = '0;
        coeffs[i]  = '0;
      end
      wr_pos     = '0;
      tap_reg    = firq_pkg::CNT_W'(firq_pkg::MAX_TAPS);
      mismatches = 0;
    endfunction

    function void set_taps(logic [firq_pkg::CNT_W-1:0] v);
      tap_reg = v;
    endfunction

    function int unsigned taps_in_use();
      if (tap_reg == 0) return 1;
      if (tap_reg > firq_pkg::MAX_TAPS) return firq_pkg::MAX_TAPS;
      return tap_reg;
    endfunction

    function logic [firq_pkg::DATA_W-1:0] filter_sample(
        logic signed [firq_pkg::DATA_W-1:0] smp);
      int unsigned                       n;
      int unsigned                       k;
      logic signed [firq_pkg::ACC_W-1:0] prod;
      logic [firq_pkg::ACC_W-1:0]        acc;
      n = taps_in_use();
      // A position left beyond a shrunk tap count is still written at its own slot.
      history[wr_pos] = smp;
      acc = '0;
      for (int unsigned i = 0; i < n; i++) begin
        k    = (wr_pos + i) % n;
        prod = coeffs[i] * history[k];
        acc  = acc + prod;
      end
      wr_pos = firq_pkg::IDX_W'((wr_pos + n - 1) % n);
      return acc[firq_pkg::ACC_W-1:firq_pkg::OUT_SHIFT];
    endfunction

    function void note_item(logic op, logic [39:0] data);
      if (op == firq_pkg::OP_LOAD) coeffs[data[5:0]] = data[21:6];
      else filtered_q.push_back(filter_sample(data[37:22]));
    endfunction

    function void check_filtered(logic [firq_pkg::DATA_W-1:0] got);
      logic [firq_pkg::DATA_W-1:0] want;
      if (filtered_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch: unexpected result filtered=%h", got);
        return;
      end
      want = filtered_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch: filtered expected %h actual %h", want, got);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;  // coeff_index[5:0], coeff_value[21:6], sample[37:22], zero
  logic        in_tuser   = 1'b0;  // opcode[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;  // filtered[15:0]
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data   = '0;

  fir_q16_tracker              tracker = new();
  int                          stall_cycles = 0;
  int                          sender_idle_pct = 0;
  int                          recv_stall_pct = 0;
  bit [firq_pkg::MAX_TAPS-1:0] coeff_loaded = '0;

  fir_filter_q16 u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // Results are checked before new inputs are noted so a stray result never
  // consumes an expectation created at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) tracker.check_filtered(out_tdata);
      if (in_tvalid && in_tready) tracker.note_item(in_tuser, in_tdata);
      if (cfg_valid && cfg_ready) tracker.set_taps(cfg_data);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready) || (cfg_valid && cfg_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [15:0] rand_word();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int unsigned effective_taps(int unsigned v);
    if (v == 0) return 1;
    if (v > firq_pkg::MAX_TAPS) return firq_pkg::MAX_TAPS;
    return v;
  endfunction

  // Valid stays high from one transaction to the next unless an idle cycle comes first.
  task automatic send_item(input logic op, input logic [5:0] idx, input logic [15:0] coeff,
                           input logic [15:0] smp);
    if (sender_idle_pct != 0) begin
      while ($urandom_range(99) < sender_idle_pct) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, smp, coeff, idx};
    if (op == firq_pkg::OP_LOAD) coeff_loaded[idx] = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_taps(input logic [6:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Loads produce no result, so the engine gets extra time after the last one.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idle(input int mode);
    case (mode)
      0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin sender_idle_pct = 80; recv_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  recv_stall_pct = 80; end
      default: begin sender_idle_pct = 27; recv_stall_pct = 27; end
    endcase
  endtask

  // A filter item is only sent once every coefficient it reads has been loaded.
  task automatic random_item(input int unsigned n);
    int gap;
    gap = -1;
    for (int i = 0; i < n && gap < 0; i++)
      if (!coeff_loaded[i]) gap = i;
    if ($urandom_range(99) < 25)
      send_item(firq_pkg::OP_LOAD, 6'($urandom), rand_word(), rand_word());
    else if (gap >= 0)
      send_item(firq_pkg::OP_LOAD, 6'(gap), rand_word(), rand_word());
    else
      send_item(firq_pkg::OP_FILTER, 6'($urandom), rand_word(), rand_word());
  endtask

  initial begin
    int          tap_plan [NUM_PHASES];
    int unsigned tap_val;
    tap_plan = '{127, 8, 64, 1, 33, 65, 5, 0, 64, 16, 2, 100, 31, 4, 64, -1};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A zero tap count acts as a single tap; the full-scale square checks the sign.
    write_taps(7'd0);
    send_item(firq_pkg::OP_LOAD, 6'd0, 16'h8000, 16'h7fff);
    send_item(firq_pkg::OP_FILTER, 6'd63, 16'h7fff, 16'h8000);
    send_item(firq_pkg::OP_FILTER, 6'd0, 16'h0000, 16'h7fff);
    send_item(firq_pkg::OP_LOAD, 6'd0, 16'h7fff, 16'h8000);
    send_item(firq_pkg::OP_FILTER, 6'd21, 16'h1234, 16'h8000);
    send_item(firq_pkg::OP_FILTER, 6'd0, 16'h0000, 16'h0000);
    send_item(firq_pkg::OP_FILTER, 6'd42, 16'hffff, 16'hffff);
    settle();

    write_taps(7'd2);
    send_item(firq_pkg::OP_LOAD, 6'd1, 16'h7fff, 16'hffff);
    send_item(firq_pkg::OP_LOAD, 6'd63, 16'h8000, 16'h5555);
    send_item(firq_pkg::OP_FILTER, 6'd17, 16'haaaa, 16'h7fff);
    send_item(firq_pkg::OP_FILTER, 6'd0, 16'h0000, 16'h8000);
    send_item(firq_pkg::OP_FILTER, 6'd0, 16'h0000, 16'h7fff);
    settle();

    write_taps(7'd3);
    send_item(firq_pkg::OP_LOAD, 6'd2, 16'hffff, 16'h0000);
    send_item(firq_pkg::OP_FILTER, 6'd0, 16'h0000, 16'h8000);
    send_item(firq_pkg::OP_FILTER, 6'd0, 16'h0000, 16'h8000);
    send_item(firq_pkg::OP_FILTER, 6'd0, 16'h0000, 16'h7fff);
    settle();

    // Shrinking the tap count keeps the history and the position.
    write_taps(7'd2);
    send_item(firq_pkg::OP_FILTER, 6'd0, 16'h0000, 16'h1234);
    send_item(firq_pkg::OP_FILTER, 6'd0, 16'h0000, 16'hedcb);
    send_item(firq_pkg::OP_FILTER, 6'd0, 16'h0000, 16'h7fff);
    settle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      tap_val = (tap_plan[ph] < 0) ? $urandom_range(127) : tap_plan[ph];
      write_taps(7'(tap_val));
      set_idle(ph % 4);
      for (int j = 0; j < ITEMS_PER_PHASE; j++) random_item(effective_taps(tap_val));
      settle();
    end

    if (tracker.mismatches == 0 && tracker.filtered_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
